/* hw/rtl/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LCVM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// next-cycle implication, checked out of reset
`define LCVM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lcvm_pkg.sv */
// types and constants of the line clip and viewport map unit
`default_nettype none

package lcvm_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int COLOR_ID_WIDTH  = 16;
	localparam int RES_WIDTH       = 14;
	localparam int COORD_WIDTH     = 32;
	localparam int DEPTH_WIDTH     = FRAC_BITS + 1;
	localparam int T_BITS          = 28;
	localparam int Q_WIDTH         = T_BITS + 1;
	localparam int TC_WIDTH        = T_BITS + 2;
	localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
	localparam int AXES            = 3;
	localparam int PLANES          = 2 * AXES;
	localparam int DIV_STAGES      = Q_WIDTH;
	localparam int SETUP_STAGES    = 2;
	localparam int BACK_STAGES     = 7;
	localparam int LATENCY         = SETUP_STAGES + DIV_STAGES + BACK_STAGES;
	localparam int CFG_INDEX_WIDTH = 4;

	localparam logic [RES_WIDTH-1:0] HRES_RESET = RES_WIDTH'(1024);
	localparam logic [RES_WIDTH-1:0] VRES_RESET = RES_WIDTH'(768);

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_HRES = 4'd0,
		REG_VRES = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] start_z;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
		logic signed [COORD_WIDTH-1:0] end_z;
		logic [COLOR_ID_WIDTH-1:0]     start_color;
		logic [COLOR_ID_WIDTH-1:0]     end_color;
	} item_t;

	typedef struct packed {
		logic                          visible;
		logic signed [COORD_WIDTH-1:0] screen_start_x;
		logic signed [COORD_WIDTH-1:0] screen_start_y;
		logic [DEPTH_WIDTH-1:0]        screen_start_depth;
		logic signed [COORD_WIDTH-1:0] screen_end_x;
		logic signed [COORD_WIDTH-1:0] screen_end_y;
		logic [DEPTH_WIDTH-1:0]        screen_end_depth;
		logic [COLOR_ID_WIDTH-1:0]     out_start_color;
		logic [COLOR_ID_WIDTH-1:0]     out_end_color;
	} result_t;

	// per plane classification made ahead of the divide
	typedef struct packed {
		logic zero_den;
		logic den_pos;
		logic par_rej;
		logic neg;
		logic above;
	} plane_flags_t;

	// segment data carried alongside the dividers
	typedef struct packed {
		logic [AXES-1:0][COORD_WIDTH-1:0] p0;
		logic [AXES-1:0][DIFF_WIDTH-1:0]  d;
		plane_flags_t [PLANES-1:0]        flg;
		logic [COLOR_ID_WIDTH-1:0]        sc;
		logic [COLOR_ID_WIDTH-1:0]        ec;
	} side_t;

endpackage

`default_nettype wire

/* hw/rtl/lcvm_setup.sv */
// front stages: differences, plane numerators, magnitudes and plane flags
`default_nettype none

module lcvm_setup (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           in_vld,
	input  wire lcvm_pkg::item_t                                item,
	output logic                                                vld_s2,
	output lcvm_pkg::side_t                                     side_s2,
	output logic [lcvm_pkg::PLANES-1:0][lcvm_pkg::COORD_WIDTH-1:0] an_s2,
	output logic [lcvm_pkg::PLANES-1:0][lcvm_pkg::COORD_WIDTH-1:0] ad_s2
);

	localparam int CW = lcvm_pkg::COORD_WIDTH;
	localparam int DW = lcvm_pkg::DIFF_WIDTH;
	localparam logic signed [DW-1:0] ONE = DW'(1) <<< lcvm_pkg::FRAC_BITS;

	logic signed [CW-1:0] p0_c [lcvm_pkg::AXES];
	logic signed [CW-1:0] p1_c [lcvm_pkg::AXES];

	logic                 vld_s1;
	logic signed [CW-1:0] p0_s1  [lcvm_pkg::AXES];
	logic signed [DW-1:0] d_s1   [lcvm_pkg::AXES];
	logic signed [DW-1:0] nlo_s1 [lcvm_pkg::AXES];
	logic signed [DW-1:0] nhi_s1 [lcvm_pkg::AXES];
	logic [lcvm_pkg::COLOR_ID_WIDTH-1:0] sc_s1, ec_s1;

	assign p0_c[0] = item.start_x;
	assign p0_c[1] = item.start_y;
	assign p0_c[2] = item.start_z;
	assign p1_c[0] = item.end_x;
	assign p1_c[1] = item.end_y;
	assign p1_c[2] = item.end_z;

	function automatic logic [CW-1:0] mag(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] n;
		n = -v;
		return v[DW-1] ? n[CW-1:0] : v[CW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: direction and the numerators of the low and high planes
	always_ff @(posedge clk) begin
		for (int i = 0; i < lcvm_pkg::AXES; i++) begin
			p0_s1[i]  <= p0_c[i];
			d_s1[i]   <= DW'(p1_c[i]) - DW'(p0_c[i]);
			nlo_s1[i] <= -ONE - DW'(p0_c[i]);
			nhi_s1[i] <= DW'(p0_c[i]) - ONE;
		end
		sc_s1 <= item.start_color;
		ec_s1 <= item.end_color;
	end

	// stage 2: magnitudes for the divider, sign and range flags
	always_ff @(posedge clk) begin
		logic [CW-1:0] ad, alo, ahi;
		logic          dz, dneg;
		for (int i = 0; i < lcvm_pkg::AXES; i++) begin
			ad   = mag(d_s1[i]);
			alo  = mag(nlo_s1[i]);
			ahi  = mag(nhi_s1[i]);
			dz   = (d_s1[i] == '0);
			dneg = d_s1[i][DW-1];
			side_s2.p0[i] <= p0_s1[i];
			side_s2.d[i]  <= d_s1[i];
			ad_s2[2*i]    <= ad;
			ad_s2[2*i+1]  <= ad;
			an_s2[2*i]    <= alo;
			an_s2[2*i+1]  <= ahi;
			// low plane: den = d
			side_s2.flg[2*i].zero_den <= dz;
			side_s2.flg[2*i].den_pos  <= !dz && !dneg;
			side_s2.flg[2*i].par_rej  <= dz && !nlo_s1[i][DW-1] && (nlo_s1[i] != '0);
			side_s2.flg[2*i].neg      <= (nlo_s1[i] != '0) && (nlo_s1[i][DW-1] != dneg);
			side_s2.flg[2*i].above    <= alo > ad;
			// high plane: den = -d
			side_s2.flg[2*i+1].zero_den <= dz;
			side_s2.flg[2*i+1].den_pos  <= dneg;
			side_s2.flg[2*i+1].par_rej  <= dz && !nhi_s1[i][DW-1] && (nhi_s1[i] != '0);
			side_s2.flg[2*i+1].neg      <= (nhi_s1[i] != '0) &&
				(nhi_s1[i][DW-1] != (!dneg && !dz));
			side_s2.flg[2*i+1].above    <= ahi > ad;
		end
		side_s2.sc <= sc_s1;
		side_s2.ec <= ec_s1;
	end

endmodule

`default_nettype wire

/* hw/rtl/lcvm_div.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module lcvm_div (
	input  wire logic                                clk,
	input  wire logic [lcvm_pkg::COORD_WIDTH-1:0]    an,
	input  wire logic [lcvm_pkg::COORD_WIDTH-1:0]    ad,
	output logic      [lcvm_pkg::Q_WIDTH-1:0]        q
);

	localparam int CW = lcvm_pkg::COORD_WIDTH;
	localparam int QW = lcvm_pkg::Q_WIDTH;
	localparam int NS = lcvm_pkg::DIV_STAGES;

	logic [CW-1:0] r_s  [NS];
	logic [CW-1:0] ad_s [NS];
	logic [QW-1:0] q_s  [NS];

	// q = floor(an * 2^T_BITS / ad), valid when an <= ad
	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [CW:0] rin;
		logic [CW:0] den;
		logic        ge;
		logic [CW:0] rdiff;
		if (k == 0) begin : g_first
			assign rin = {1'b0, an};
			assign den = {1'b0, ad};
		end else begin : g_next
			assign rin = {r_s[k-1], 1'b0};
			assign den = {1'b0, ad_s[k-1]};
		end
		assign ge    = rin >= den;
		assign rdiff = rin - den;
		always_ff @(posedge clk) begin
			r_s[k]  <= ge ? rdiff[CW-1:0] : rin[CW-1:0];
			ad_s[k] <= den[CW-1:0];
		end
		if (k == 0) begin : g_q_first
			always_ff @(posedge clk) begin
				q_s[k] <= {{(QW-1){1'b0}}, ge};
			end
		end else begin : g_q_next
			always_ff @(posedge clk) begin
				q_s[k] <= {q_s[k-1][QW-2:0], ge};
			end
		end
	end

	assign q = q_s[NS-1];

endmodule

`default_nettype wire

/* hw/rtl/lcvm_back.sv */
// back stages: entering/leaving reduction, interpolation, viewport map
`default_nettype none

module lcvm_back (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             in_vld,
	input  wire lcvm_pkg::side_t                                  side,
	input  wire logic [lcvm_pkg::PLANES-1:0][lcvm_pkg::Q_WIDTH-1:0] q,
	input  wire logic [lcvm_pkg::RES_WIDTH-1:0]                   hres,
	input  wire logic [lcvm_pkg::RES_WIDTH-1:0]                   vres,
	output logic                                                  done_s7,
	output lcvm_pkg::result_t                                     res_s7
);

	localparam int CW = lcvm_pkg::COORD_WIDTH;
	localparam int TW = lcvm_pkg::TC_WIDTH;
	localparam int TB = lcvm_pkg::T_BITS;
	localparam int FB = lcvm_pkg::FRAC_BITS;
	localparam int ZW = lcvm_pkg::DEPTH_WIDTH;
	localparam int PW = lcvm_pkg::DIFF_WIDTH + TW;
	localparam int MW = CW + lcvm_pkg::RES_WIDTH + 1;
	localparam int SW = MW + 1;
	localparam int NA = lcvm_pkg::AXES;
	localparam int NP = lcvm_pkg::PLANES;

	localparam logic signed [TW-1:0] T_ONE   = TW'(1) <<< TB;
	localparam logic signed [TW-1:0] T_ABOVE = T_ONE + TW'(1);
	localparam logic signed [TW-1:0] T_BELOW = -TW'(1);
	localparam logic signed [PW-1:0] RND     = PW'(1) <<< (TB - 1);
	localparam logic signed [CW+1:0] Z_BIAS  = (CW+2)'((1 << FB) + 1);
	localparam logic signed [CW+1:0] Z_ONE   = (CW+2)'(1 << FB);
	localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	lcvm_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	logic signed [TW-1:0] ent_s1 [NP];
	logic signed [TW-1:0] lev_s1 [NP];
	logic                 rej_s1, rej_s2, rej_s3;
	logic signed [TW-1:0] te_s2 [NA];
	logic signed [TW-1:0] tl_s2 [NA];
	logic signed [TW-1:0] te_s3, tl_s3;
	logic                 vis_s4, te_pos_s4, tl_lt_s4;
	logic signed [PW-1:0] pa_s4 [NA];
	logic signed [PW-1:0] pb_s4 [NA];
	logic                 vis_s5, vis_s6;
	logic signed [CW-1:0] a_s5 [NA];
	logic signed [CW-1:0] b_s5 [NA];
	logic signed [MW-1:0] xy_s6 [4];
	logic [ZW-1:0]        dep_s6 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			done_s7 <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			done_s7 <= vld_s6;
		end
	end

	// stage 1: plane parameters sorted into entering and leaving
	always_ff @(posedge clk) begin
		logic signed [TW-1:0] tc;
		logic                 rj;
		rj = 1'b0;
		for (int j = 0; j < NP; j++) begin
			if (side.flg[j].neg)
				tc = T_BELOW;
			else if (side.flg[j].above)
				tc = T_ABOVE;
			else
				tc = TW'(q[j]);
			ent_s1[j] <= (!side.flg[j].zero_den && side.flg[j].den_pos) ? tc : '0;
			lev_s1[j] <= (!side.flg[j].zero_den && !side.flg[j].den_pos) ? tc : T_ONE;
			rj = rj | side.flg[j].par_rej;
		end
		rej_s1  <= rj;
		side_s1 <= side;
	end

	// stage 2: reduce per axis
	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			te_s2[i] <= (ent_s1[2*i] > ent_s1[2*i+1]) ? ent_s1[2*i] : ent_s1[2*i+1];
			tl_s2[i] <= (lev_s1[2*i] < lev_s1[2*i+1]) ? lev_s1[2*i] : lev_s1[2*i+1];
		end
		rej_s2  <= rej_s1;
		side_s2 <= side_s1;
	end

	// stage 3: reduce over the axes
	always_ff @(posedge clk) begin
		logic signed [TW-1:0] te01, tl01;
		te01 = (te_s2[0] > te_s2[1]) ? te_s2[0] : te_s2[1];
		tl01 = (tl_s2[0] < tl_s2[1]) ? tl_s2[0] : tl_s2[1];
		te_s3   <= (te01 > te_s2[2]) ? te01 : te_s2[2];
		tl_s3   <= (tl01 < tl_s2[2]) ? tl01 : tl_s2[2];
		rej_s3  <= rej_s2;
		side_s3 <= side_s2;
	end

	// stage 4: visibility and the interpolation products
	always_ff @(posedge clk) begin
		vis_s4    <= !rej_s3 && (te_s3 <= tl_s3);
		te_pos_s4 <= te_s3 > '0;
		tl_lt_s4  <= tl_s3 < T_ONE;
		for (int i = 0; i < NA; i++) begin
			pa_s4[i] <= $signed(side_s3.d[i]) * te_s3;
			pb_s4[i] <= $signed(side_s3.d[i]) * tl_s3;
		end
		side_s4 <= side_s3;
	end

	// stage 5: round to nearest, ties up, and move the endpoints
	always_ff @(posedge clk) begin
		logic signed [PW-1:0] ra, rb;
		logic signed [CW-1:0] p0;
		for (int i = 0; i < NA; i++) begin
			ra = (pa_s4[i] + RND) >>> TB;
			rb = (pb_s4[i] + RND) >>> TB;
			p0 = $signed(side_s4.p0[i]);
			a_s5[i] <= te_pos_s4 ? p0 + ra[CW-1:0] : p0;
			b_s5[i] <= tl_lt_s4 ? p0 + rb[CW-1:0] : $signed(side_s4.p0[i] + side_s4.d[i][CW-1:0]);
		end
		vis_s5  <= vis_s4;
		side_s5 <= side_s4;
	end

	// stage 6: viewport scale and depth
	function automatic logic [ZW-1:0] depth(input logic signed [CW-1:0] z);
		logic signed [CW+1:0] v;
		v = ((CW+2)'(z) + Z_BIAS) >>> 1;
		if (v < 0)
			return '0;
		else if (v > Z_ONE)
			return Z_ONE[ZW-1:0];
		else
			return v[ZW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		xy_s6[0]  <= a_s5[0] * $signed({1'b0, hres});
		xy_s6[1]  <= a_s5[1] * $signed({1'b0, vres});
		xy_s6[2]  <= b_s5[0] * $signed({1'b0, hres});
		xy_s6[3]  <= b_s5[1] * $signed({1'b0, vres});
		dep_s6[0] <= depth(a_s5[2]);
		dep_s6[1] <= depth(b_s5[2]);
		vis_s6    <= vis_s5;
		side_s6   <= side_s5;
	end

	// stage 7: offset, halve with ties up, saturate
	function automatic logic signed [CW-1:0] offset(input logic [lcvm_pkg::RES_WIDTH-1:0] r);
		logic signed [CW-1:0] rs;
		rs = $signed(CW'(r));
		return ((rs - CW'(1)) <<< FB) + CW'(1);
	endfunction

	function automatic logic signed [CW-1:0] place(input logic signed [MW-1:0] p,
		input logic signed [CW-1:0] off);
		logic signed [SW-1:0] v;
		v = (SW'(p) + SW'(off)) >>> 1;
		if (v > SAT_MAX)
			return SAT_MAX[CW-1:0];
		else if (v < SAT_MIN)
			return SAT_MIN[CW-1:0];
		else
			return v[CW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		logic signed [CW-1:0] offh, offv;
		offh = offset(hres);
		offv = offset(vres);
		res_s7.visible            <= vis_s6;
		res_s7.screen_start_x     <= vis_s6 ? place(xy_s6[0], offh) : '0;
		res_s7.screen_start_y     <= vis_s6 ? place(xy_s6[1], offv) : '0;
		res_s7.screen_start_depth <= vis_s6 ? dep_s6[0] : '0;
		res_s7.screen_end_x       <= vis_s6 ? place(xy_s6[2], offh) : '0;
		res_s7.screen_end_y       <= vis_s6 ? place(xy_s6[3], offv) : '0;
		res_s7.screen_end_depth   <= vis_s6 ? dep_s6[1] : '0;
		res_s7.out_start_color    <= side_s6.sc;
		res_s7.out_end_color      <= side_s6.ec;
	end

endmodule

`default_nettype wire

/* hw/rtl/line_clip_viewport_map_unit.sv */
// top level of the line clip and viewport map unit
`default_nettype none

`include "assert_macros.svh"

// Clips one 3D segment (signed Q16.16 device coordinates) against the cube
// [-1,1]^3 and maps the clipped endpoints to the viewport.
// Input channel: a word on item is taken at a rising edge with start high
// and busy low. busy is high only during and just after reset.
// Result channel: done is high for exactly one cycle with the word on
// result; the receiver cannot hold it off and none is needed, since the
// pipeline never stalls.
// Pipeline: a segment taken at the accepting edge passes 2 setup, 29 divider
// and 7 back stages before done goes high with its word.
// Throughput: one segment per clock, set by the one-bit-per-stage dividers,
// six of them in parallel, one per clip plane.
// Config: cfg_index 0 is the horizontal resolution, 1 the vertical one;
// a write lands when cfg_valid and cfg_ready are high. Other indexes are
// ignored. Write only while no segment is in flight.
// Reset: pipeline valid bits clear, resolutions return to 1024 x 768.
module line_clip_viewport_map_unit (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     start,
	output logic                                          busy,
	input  wire lcvm_pkg::item_t                          item,
	output logic                                          done,
	output lcvm_pkg::result_t                             result,
	input  wire logic                                     cfg_valid,
	output logic                                          cfg_ready,
	input  wire logic [lcvm_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  wire logic [lcvm_pkg::RES_WIDTH-1:0]           cfg_data
);

	localparam int NS = lcvm_pkg::DIV_STAGES;
	localparam int NP = lcvm_pkg::PLANES;

	logic                                  busy_q;
	logic [lcvm_pkg::RES_WIDTH-1:0]        hres_q, vres_q;
	logic                                  acc;

	logic                                  vld_s2;
	lcvm_pkg::side_t                       side_s2;
	logic [NP-1:0][lcvm_pkg::COORD_WIDTH-1:0] an_s2, ad_s2;
	logic [NP-1:0][lcvm_pkg::Q_WIDTH-1:0]  quo;

	// side data and valid bits ride next to the divider stages
	logic                                  dvld_q  [NS];
	lcvm_pkg::side_t                       dside_q [NS];

	assign acc       = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = !busy_q;

	// busy is set in reset and drops at the next clock edge after release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// resolution registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hres_q <= lcvm_pkg::HRES_RESET;
			vres_q <= lcvm_pkg::VRES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lcvm_pkg::REG_HRES: hres_q <= cfg_data;
				lcvm_pkg::REG_VRES: vres_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lcvm_setup u_setup (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (acc),
		.item    (item),
		.vld_s2  (vld_s2),
		.side_s2 (side_s2),
		.an_s2   (an_s2),
		.ad_s2   (ad_s2)
	);

	// one divider per clip plane
	for (genvar j = 0; j < NP; j++) begin : g_div
		lcvm_div u_div (
			.clk (clk),
			.an  (an_s2[j]),
			.ad  (ad_s2[j]),
			.q   (quo[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++)
				dvld_q[k] <= 1'b0;
		end else begin
			dvld_q[0] <= vld_s2;
			for (int k = 1; k < NS; k++)
				dvld_q[k] <= dvld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		dside_q[0] <= side_s2;
		for (int k = 1; k < NS; k++)
			dside_q[k] <= dside_q[k-1];
	end

	lcvm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (dvld_q[NS-1]),
		.side    (dside_q[NS-1]),
		.q       (quo),
		.hres    (hres_q),
		.vres    (vres_q),
		.done_s7 (done),
		.res_s7  (result)
	);

	// every result traces back to a segment accepted with start high and busy low
	`LCVM_ASSERT(a_done_has_item, done |-> $past(start && !busy, lcvm_pkg::LATENCY), "result without item")
	// config writes land in the addressed register
	`LCVM_ASSERT_NEXT(a_cfg_hres, cfg_valid && cfg_ready && cfg_index == lcvm_pkg::REG_HRES, hres_q == $past(cfg_data), "hres write lost")
	`LCVM_ASSERT_NEXT(a_cfg_vres, cfg_valid && cfg_ready && cfg_index == lcvm_pkg::REG_VRES, vres_q == $past(cfg_data), "vres write lost")

endmodule

`default_nettype wire
